// File: src/masked_histogram_matching_macros.svh
// Assertion macros shared by the RTL.
`ifndef MASKED_HISTOGRAM_MATCHING_MACROS_SVH
`define MASKED_HISTOGRAM_MATCHING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MHM_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed");
`define MHM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define MHM_ASSERT(lbl, clk, rst, cond)
`define MHM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/mhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mhm_pkg;
  localparam int CHANNELS = 3;
  localparam int BINS = 256;
  localparam int BIN_W = $clog2(BINS);
  localparam int CNT_W = 21;
  localparam int SUM_W = CNT_W + BIN_W;
  localparam int PROD_W = 2 * SUM_W;
  localparam logic [1:0] CMD_ACC = 2'd0;
  localparam logic [1:0] CMD_FIN = 2'd1;
  localparam logic [1:0] CMD_REM = 2'd2;
endpackage
`default_nettype wire

// File: src/mhm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/masked_histogram_matching.sv
`timescale 1ns / 1ps
`default_nettype none
`include "masked_histogram_matching_macros.svh"
// Masked per-channel histogram matching. An accumulate beat does a read-modify-write of the
// per-channel bin RAMs and a remap beat a read-then-register of the per-channel remap table
// RAMs, and the remap result also waits on out_stall. A finish beat runs, per channel, a
// totals sweep over all bins, then a two-pointer walk that reads each target bin, loads each
// source bin and does at most 512 compares, every compare costing two passes through the
// single shared 29x29 multiplier; after the last channel it runs a clearing sweep of the
// histograms. After reset the block runs a clearing sweep over all RAMs and holds in_stall
// high meanwhile. Command 3 is dropped.
module masked_histogram_matching (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] mask,
  input  wire logic [7:0] src_c0,
  input  wire logic [7:0] src_c1,
  input  wire logic [7:0] src_c2,
  input  wire logic [7:0] tgt_c0,
  input  wire logic [7:0] tgt_c1,
  input  wire logic [7:0] tgt_c2,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_c0,
  output logic      [7:0] out_c1,
  output logic      [7:0] out_c2
);
  localparam int CH = mhm_pkg::CHANNELS;
  localparam int BW = mhm_pkg::BIN_W;
  localparam int CW = mhm_pkg::CNT_W;
  localparam int SW = mhm_pkg::SUM_W;
  localparam int PW = mhm_pkg::PROD_W;

  typedef enum logic [3:0] {
    CLR, IDLE, ACC_RD, ACC_WR, REM_RD, REM_WR, TOT_RD, TOT_ADD,
    T_RD, T_ADD, CHK, S_RD, S_ADD, MUL1, MUL2, CMP
  } state_t;

  state_t        state;
  logic          clr_lut;
  logic [BW-1:0] idx;
  logic [BW:0]   b;
  logic [1:0]    ch;
  logic          s_loaded;
  logic [SW-1:0] stot, ttot, scum, tcum;
  logic [PW-1:0] p1, p2;
  logic [1:0]    item_cmd;
  logic          item_sel;
  logic [BW-1:0] item_src [CH];
  logic [BW-1:0] item_tgt [CH];

  logic [CW-1:0] src_rd [CH];
  logic [CW-1:0] tgt_rd [CH];
  logic [BW-1:0] lut_rd [CH];

  logic          lut_wr, adv_i;
  logic [BW-1:0] lut_val;
  logic [CW-1:0] src_sel, tgt_sel;
  logic [SW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          out_load;

  assign in_stall = (state != IDLE);
  assign src_sel  = src_rd[ch];
  assign tgt_sel  = tgt_rd[ch];
  assign mul_a    = (state == MUL1) ? scum : tcum;
  assign mul_b    = (state == MUL1) ? ttot : stot;
  assign prod     = PW'(mul_a * mul_b);
  assign out_load = (state == REM_WR) && (!out_valid || !out_stall);

  always_comb begin
    lut_wr  = 1'b0;
    lut_val = '0;
    case (state)
      CHK: begin
        if (ttot == '0 || tcum == '0) begin
          lut_wr  = 1'b1;
          lut_val = '0;
        end else if (stot == '0 || b[BW]) begin
          lut_wr  = 1'b1;
          lut_val = '1;
        end
      end
      CMP: begin
        if (p1 >= p2) begin
          lut_wr  = 1'b1;
          lut_val = b[BW-1:0];
        end
      end
      default: begin
        lut_wr = 1'b0;
      end
    endcase
    adv_i = lut_wr;
  end

  for (genvar c = 0; c < CH; c++) begin : g_ch
    logic          hist_we;
    logic [BW-1:0] s_raddr, t_raddr, s_waddr, t_waddr;
    logic [CW-1:0] s_wdata, t_wdata;
    logic          l_we;

    assign hist_we = (state == CLR) || (state == ACC_WR && item_sel);
    assign s_raddr = (state == ACC_RD) ? item_src[c] :
                     (state == S_RD) ? b[BW-1:0] : idx;
    assign t_raddr = (state == ACC_RD) ? item_tgt[c] : idx;
    assign s_waddr = (state == CLR) ? idx : item_src[c];
    assign t_waddr = (state == CLR) ? idx : item_tgt[c];
    assign s_wdata = (state == CLR) ? '0 :
                     (src_rd[c] == '1) ? src_rd[c] : src_rd[c] + CW'(1);
    assign t_wdata = (state == CLR) ? '0 :
                     (tgt_rd[c] == '1) ? tgt_rd[c] : tgt_rd[c] + CW'(1);
    assign l_we    = (state == CLR && clr_lut) || (lut_wr && ch == 2'(c));

    mhm_ram #(.WIDTH(CW), .DEPTH(mhm_pkg::BINS)) u_src (
      .clk(clk), .we(hist_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(src_rd[c])
    );
    mhm_ram #(.WIDTH(CW), .DEPTH(mhm_pkg::BINS)) u_tgt (
      .clk(clk), .we(hist_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(tgt_rd[c])
    );
    mhm_ram #(.WIDTH(BW), .DEPTH(mhm_pkg::BINS)) u_lut (
      .clk(clk), .we(l_we), .waddr(idx),
      .wdata((state == CLR) ? '0 : lut_val),
      .raddr(item_tgt[c]), .rdata(lut_rd[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLR;
      clr_lut   <= 1'b1;
      idx       <= '0;
      b         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        CLR: begin
          idx <= idx + BW'(1);
          if (idx == '1) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            item_cmd    <= cmd;
            item_sel    <= (mask != '0);
            item_src[0] <= src_c0;
            item_src[1] <= src_c1;
            item_src[2] <= src_c2;
            item_tgt[0] <= tgt_c0;
            item_tgt[1] <= tgt_c1;
            item_tgt[2] <= tgt_c2;
            case (cmd)
              mhm_pkg::CMD_ACC: state <= ACC_RD;
              mhm_pkg::CMD_REM: state <= REM_RD;
              mhm_pkg::CMD_FIN: begin
                state <= TOT_RD;
                ch    <= '0;
                idx   <= '0;
                stot  <= '0;
                ttot  <= '0;
              end
              default: state <= IDLE;
            endcase
          end
        end
        ACC_RD: state <= ACC_WR;
        ACC_WR: state <= IDLE;
        REM_RD: state <= REM_WR;
        REM_WR: begin
          if (out_load) begin
            out_valid <= 1'b1;
            out_c0    <= item_sel ? lut_rd[0] : item_tgt[0];
            out_c1    <= item_sel ? lut_rd[1] : item_tgt[1];
            out_c2    <= item_sel ? lut_rd[2] : item_tgt[2];
            state     <= IDLE;
          end
        end
        TOT_RD: state <= TOT_ADD;
        TOT_ADD: begin
          stot <= stot + SW'(src_sel);
          ttot <= ttot + SW'(tgt_sel);
          idx  <= idx + BW'(1);
          if (idx == '1) begin
            b        <= '0;
            scum     <= '0;
            tcum     <= '0;
            s_loaded <= 1'b0;
            state    <= T_RD;
          end else begin
            state <= TOT_RD;
          end
        end
        T_RD: state <= T_ADD;
        T_ADD: begin
          tcum  <= tcum + SW'(tgt_sel);
          state <= CHK;
        end
        CHK: begin
          if (!adv_i) begin
            state <= s_loaded ? MUL1 : S_RD;
          end
        end
        S_RD: state <= S_ADD;
        S_ADD: begin
          scum     <= scum + SW'(src_sel);
          s_loaded <= 1'b1;
          state    <= MUL1;
        end
        MUL1: begin
          p1    <= prod;
          state <= MUL2;
        end
        MUL2: begin
          p2    <= prod;
          state <= CMP;
        end
        CMP: begin
          if (!adv_i) begin
            b        <= b + (BW+1)'(1);
            s_loaded <= 1'b0;
            state    <= CHK;
          end
        end
        default: state <= IDLE;
      endcase
      if (adv_i) begin
        idx <= idx + BW'(1);
        if (idx == '1) begin
          if (ch == 2'(CH - 1)) begin
            clr_lut <= 1'b0;
            state   <= CLR;
          end else begin
            ch    <= ch + 2'd1;
            stot  <= '0;
            ttot  <= '0;
            state <= TOT_RD;
          end
        end else begin
          state <= T_RD;
        end
      end
    end
  end

  `MHM_ASSERT(a_b_range, clk, rst, !b[BW] || b[BW-1:0] == '0)
  `MHM_ASSERT_IMP(a_mul_ready, clk, rst, state == MUL1, s_loaded && !b[BW])
  `MHM_ASSERT_IMP(a_out_src, clk, rst, $rose(out_valid), $past(state) == REM_WR)
  `MHM_ASSERT_IMP(a_rem_cmd, clk, rst, state == REM_WR, item_cmd == mhm_pkg::CMD_REM)
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_ITEMS = 1150;
  localparam int NCH = mhm_pkg::CHANNELS;
  localparam int NBINS = mhm_pkg::BINS;
  localparam int CNT_W = mhm_pkg::CNT_W;
  localparam int TABLE_SZ = NCH * NBINS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] mask;
    logic [7:0] s0, s1, s2;
    logic [7:0] t0, t1, t2;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] c0, c1, c2;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = mhm_pkg::CMD_ACC;
  logic [7:0] mask = '0;
  logic [7:0] src_c0 = '0, src_c1 = '0, src_c2 = '0;
  logic [7:0] tgt_c0 = '0, tgt_c1 = '0, tgt_c2 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_c0, out_c1, out_c2;

  masked_histogram_matching dut (.*);

  pixel_beat_t pending_beats[$];
  pixel_out_t expected_pixels[$];
  logic [CNT_W-1:0] src_hist[TABLE_SZ];
  logic [CNT_W-1:0] tgt_hist[TABLE_SZ];
  logic [7:0] remap_lut[TABLE_SZ];
  int accepted_beats = 0;
  int errors = 0;
  logic beat_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL masked_histogram_matching");
    $finish;
  end

  function automatic int idle_pct(input bit sender);
    if (accepted_beats < 400) return sender ? 18 : 58;
    if (accepted_beats < 800) return sender ? 58 : 18;
    return 0;
  endfunction

  function automatic void build_lut(input int ch);
    longint unsigned scum[NBINS], tcum[NBINS];
    longint unsigned s, t;
    int b;
    s = 0;
    t = 0;
    for (int i = 0; i < NBINS; i++) begin
      s += src_hist[ch*NBINS+i];
      t += tgt_hist[ch*NBINS+i];
      scum[i] = s;
      tcum[i] = t;
    end
    b = 0;
    for (int i = 0; i < NBINS; i++) begin
      if (t == 0 || tcum[i] == 0) remap_lut[ch*NBINS+i] = 8'd0;
      else if (s == 0) remap_lut[ch*NBINS+i] = 8'd255;
      else begin
        while (b < NBINS && scum[b] * t < tcum[i] * s) b++;
        remap_lut[ch*NBINS+i] = (b < NBINS) ? 8'(b) : 8'd255;
      end
    end
  endfunction

  function automatic void bump_bin(inout logic [CNT_W-1:0] bin);
    if (bin != CNT_MAX) bin = bin + 1'b1;
  endfunction

  function automatic void predict_beat(input pixel_beat_t pb);
    logic [7:0] sv[3], tv[3];
    pixel_out_t po;
    sv = '{pb.s0, pb.s1, pb.s2};
    tv = '{pb.t0, pb.t1, pb.t2};
    case (pb.cmd)
      mhm_pkg::CMD_ACC: begin
        if (pb.mask != 0)
          for (int c = 0; c < NCH; c++) begin
            bump_bin(src_hist[c*NBINS+sv[c]]);
            bump_bin(tgt_hist[c*NBINS+tv[c]]);
          end
      end
      mhm_pkg::CMD_FIN: begin
        for (int c = 0; c < NCH; c++) build_lut(c);
        for (int i = 0; i < TABLE_SZ; i++) begin
          src_hist[i] = '0;
          tgt_hist[i] = '0;
        end
      end
      mhm_pkg::CMD_REM: begin
        po.c0 = (pb.mask != 0) ? remap_lut[pb.t0] : pb.t0;
        po.c1 = (pb.mask != 0) ? remap_lut[NBINS+pb.t1] : pb.t1;
        po.c2 = (pb.mask != 0) ? remap_lut[2*NBINS+pb.t2] : pb.t2;
        expected_pixels.push_back(po);
      end
      default: ;
    endcase
  endfunction

  task automatic push_beat(input logic [1:0] c, input logic [7:0] m,
                           input logic [7:0] a0, a1, a2, b0, b1, b2);
    pending_beats.push_back({c, m, a0, a1, a2, b0, b1, b2});
  endtask

  function automatic logic [7:0] skewed(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, spread);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || beat_taken) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct(1)) begin
          pixel_beat_t pb;
          pb = pending_beats.pop_front();
          {cmd, mask, src_c0, src_c1, src_c2, tgt_c0, tgt_c1, tgt_c2} <= pb;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(0));
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_beat({cmd, mask, src_c0, src_c1, src_c2, tgt_c0, tgt_c1, tgt_c2});
        accepted_beats <= accepted_beats + 1;
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected out beat %h %h %h", out_c0, out_c1, out_c2);
          errors++;
        end else begin
          pixel_out_t po;
          po = expected_pixels.pop_front();
          if (out_c0 !== po.c0) begin
            $error("out_c0 expected %h got %h", po.c0, out_c0);
            errors++;
          end
          if (out_c1 !== po.c1) begin
            $error("out_c1 expected %h got %h", po.c1, out_c1);
            errors++;
          end
          if (out_c2 !== po.c2) begin
            $error("out_c2 expected %h got %h", po.c2, out_c2);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int n, base, spr;
    for (int i = 0; i < TABLE_SZ; i++) begin
      src_hist[i] = '0;
      tgt_hist[i] = '0;
      remap_lut[i] = '0;
    end
    // table still at reset, unused command, empty finish
    push_beat(mhm_pkg::CMD_REM, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'h80, 8'h01);
    push_beat(mhm_pkg::CMD_REM, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'h80, 8'h01);
    push_beat(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
    push_beat(mhm_pkg::CMD_FIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_beat(mhm_pkg::CMD_REM, 8'h01, 8'h00, 8'h00, 8'h00, 8'h10, 8'hff, 8'h00);
    push_beat(mhm_pkg::CMD_ACC, 8'h00, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
    push_beat(mhm_pkg::CMD_ACC, 8'h01, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff);
    push_beat(mhm_pkg::CMD_ACC, 8'hff, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00);
    push_beat(mhm_pkg::CMD_ACC, 8'h80, 8'h7f, 8'h80, 8'h01, 8'h80, 8'h7f, 8'hfe);
    push_beat(mhm_pkg::CMD_ACC, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_beat(mhm_pkg::CMD_FIN, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_beat(mhm_pkg::CMD_REM, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_beat(mhm_pkg::CMD_REM, 8'h01, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff);
    push_beat(mhm_pkg::CMD_REM, 8'h40, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h80, 8'h01);
    push_beat(mhm_pkg::CMD_REM, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7f, 8'h80, 8'h01);
    push_beat(CMD_UNUSED, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc);
    while (pending_beats.size() < NUM_ITEMS) begin
      n = $urandom_range(4, 90);
      base = $urandom_range(0, 255);
      spr = $urandom_range(0, 255);
      for (int i = 0; i < n; i++)
        push_beat(mhm_pkg::CMD_ACC,
                  ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                  skewed(base, spr), skewed(base / 2, spr), 8'($urandom),
                  skewed(255 - base, spr / 2), 8'($urandom), skewed(base, 16));
      if ($urandom_range(3) == 0)
        push_beat(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(4) == 0)
        push_beat(mhm_pkg::CMD_REM, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      push_beat(mhm_pkg::CMD_FIN, 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      n = $urandom_range(15, 45);
      for (int i = 0; i < n; i++)
        push_beat(mhm_pkg::CMD_REM,
                  ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                  8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_beats.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("PASS masked_histogram_matching");
    end else begin
      $display("FAIL masked_histogram_matching");
    end
    $finish;
  end
endmodule
